// ===== src/cab_pkg.sv =====
// shared types and constants of the cyclic buffer slot manager
package cab_pkg;

  // slot numbers are three bits wide, so at most eight slots are usable
  localparam int MAX_SLOTS = 8;
  localparam int NUM_SLOTS = (MAX_SLOTS > 8) ? 8 : MAX_SLOTS;
  localparam int SLOT_W = 3;
  localparam int CFG_W = 4;
  localparam int COUNT_W = 8;
  localparam logic [CFG_W-1:0] USABLE_MAX = CFG_W'(NUM_SLOTS);
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_NOTHING = 3'd2,
    ST_UNUSED  = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_HOLD = 2'd2
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
  } cab_in_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_out;
  } cab_out_t;

  // request from the sequencer to the count unit
  typedef struct packed {
    logic [SLOT_W-1:0] addr;
    cnt_cmd_t          cmd;
  } cnt_req_t;

  // flags of the addressed reader count
  typedef struct packed {
    logic is_zero;
    logic is_full;
  } cnt_flags_t;

endpackage

// ===== src/cab_count_unit.sv =====
// reader count registers with one shared increment, decrement and compare unit
module cab_count_unit (
  input  logic                clk,
  input  logic                rst,
  input  cab_pkg::cnt_req_t   req,
  output cab_pkg::cnt_flags_t flags
);
  import cab_pkg::*;

  logic [COUNT_W-1:0] counts [NUM_SLOTS];
  logic [COUNT_W-1:0] cur;

  // read the addressed count and compare it
  always_comb begin
    cur = counts[req.addr];
    flags.is_zero = (cur == '0);
    flags.is_full = (cur == {COUNT_W{1'b1}});
  end

  // single update per cycle, increment saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      case (req.cmd)
        CNT_INC: begin
          if (!flags.is_full) counts[req.addr] <= cur + COUNT_W'(1);
        end
        CNT_DEC: begin
          if (!flags.is_zero) counts[req.addr] <= cur - COUNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/cyclic_async_buffer_slot_manager.sv =====
// top level: request sequencer, slot scan and result register
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall   in_data (op, slot)
//   out       output     out_valid / out_stall out_data (status, slot_out)
//   cfg       input      cfg_wr_en             cfg_wr_data (slots_in_use)
//
// a read, release or unused op: res loads in EXEC, out_data on leaving HOLD
// a write scans one slot per cycle through the shared count unit, from slot 0 up to the
// usable slot count; a new request is accepted only once the block is back in IDLE
// in_stall is high from accept until the result enters the output register
// out_stall holds the result register and, once it is full, the next result
// rst is synchronous: counts clear, nothing written, slots_in_use back to 8
module cyclic_async_buffer_slot_manager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cab_pkg::cab_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cab_pkg::cab_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [cab_pkg::CFG_W-1:0]     cfg_wr_data
);
  import cab_pkg::*;

  state_t            state, state_next;
  cab_in_t           req_r;
  logic [CFG_W-1:0]  idx;
  logic              has_recent;
  logic [SLOT_W-1:0] recent_slot;
  logic [CFG_W-1:0]  slots_in_use;
  cab_out_t          res;
  cab_out_t          res_next;
  logic              done;
  logic              claim;
  logic [CFG_W-1:0]  usable;
  logic              in_accept;
  logic              out_free;
  cnt_req_t          cnt_req;
  cnt_flags_t        cnt_flags;

  cab_count_unit u_count (
    .clk   (clk),
    .rst   (rst),
    .req   (cnt_req),
    .flags (cnt_flags)
  );

  // usable slot count, saturated to what the counts cover
  assign usable = (slots_in_use > USABLE_MAX) ? USABLE_MAX : slots_in_use;

  assign in_stall = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (done) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: count unit request and finished result
  always_comb begin
    cnt_req.addr = req_r.slot;
    cnt_req.cmd = CNT_NONE;
    done = 1'b0;
    claim = 1'b0;
    res_next.status = ST_OK;
    res_next.slot_out = '0;
    if (state == S_EXEC) begin
      case (req_r.op)
        OP_WRITE: begin
          cnt_req.addr = idx[SLOT_W-1:0];
          if (idx >= usable) begin
            done = 1'b1;
            res_next.status = ST_NO_FREE;
          end else if (cnt_flags.is_zero &&
                       !(has_recent && recent_slot == idx[SLOT_W-1:0])) begin
            done = 1'b1;
            claim = 1'b1;
            res_next.slot_out = idx[SLOT_W-1:0];
          end
        end
        OP_READ: begin
          cnt_req.addr = recent_slot;
          done = 1'b1;
          if (has_recent && {1'b0, recent_slot} < usable) begin
            cnt_req.cmd = CNT_INC;
            res_next.slot_out = recent_slot;
          end else begin
            res_next.status = ST_NOTHING;
          end
        end
        OP_RELEASE: begin
          done = 1'b1;
          if ({1'b0, req_r.slot} >= usable) begin
            res_next.status = ST_INVALID;
          end else if (cnt_flags.is_zero) begin
            res_next.status = ST_UNUSED;
          end else begin
            cnt_req.cmd = CNT_DEC;
          end
        end
        default: done = 1'b1;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      has_recent <= 1'b0;
      recent_slot <= '0;
      slots_in_use <= CFG_RESET;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) slots_in_use <= cfg_wr_data;
      if (in_accept) begin
        idx <= '0;
      end else if (state == S_EXEC && !done) begin
        idx <= idx + CFG_W'(1);
      end
      if (claim) begin
        has_recent <= 1'b1;
        recent_slot <= idx[SLOT_W-1:0];
      end
      if (state == S_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) req_r <= in_data;
    if (state == S_EXEC && done) res <= res_next;
    if (state == S_HOLD && out_free) out_data <= res;
  end

  // checks
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (idx <= usable))
    else $error("slot scan ran past the usable slots");

  a_recent_sticky: assert property (@(posedge clk) disable iff (rst)
    has_recent |=> has_recent)
    else $error("most recent slot lost without reset");

  a_error_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && res.status != ST_OK) |-> (res.slot_out == '0))
    else $error("error result carries a slot number");

  a_claim_in_range: assert property (@(posedge clk) disable iff (rst)
    claim |-> ({1'b0, idx[SLOT_W-1:0]} < usable && cnt_flags.is_zero))
    else $error("write claimed an unusable or busy slot");

endmodule

// ===== tb/cab_slot_checker.sv =====
// checker for the slot manager: follows both channels, predicts every result and compares
module cab_slot_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  cab_pkg::cab_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  cab_pkg::cab_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic [cab_pkg::CFG_W-1:0] cfg_wr_data,
  output int                        errors,
  output int                        outstanding,
  output int                        checked,
  output int                        error_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import cab_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

  // predicted slot table and register copy
  logic [COUNT_W-1:0] readers [NUM_SLOTS];
  logic               have_recent;
  logic [SLOT_W-1:0]  recent;
  logic [CFG_W-1:0]   slot_limit;
  cab_out_t           expected_results [$];

  // apply one request to the predicted table and return its result
  function automatic cab_out_t predict_result(cab_in_t req);
    int       usable;
    logic     found;
    cab_out_t res;
    usable = (int'(slot_limit) > NUM_SLOTS) ? NUM_SLOTS : int'(slot_limit);
    found = 1'b0;
    res.status = ST_OK;
    res.slot_out = '0;
    case (req.op)
      OP_WRITE: begin
        // lowest usable slot with no readers that is not the newest message
        res.status = ST_NO_FREE;
        for (int i = 0; i < usable; i++) begin
          if (!found && readers[i] == '0 && !(have_recent && int'(recent) == i)) begin
            found = 1'b1;
            have_recent = 1'b1;
            recent = SLOT_W'(i);
            res.status = ST_OK;
            res.slot_out = SLOT_W'(i);
          end
        end
      end
      OP_READ: begin
        // newest slot must lie inside the current usable range
        if (have_recent && int'(recent) < usable) begin
          if (readers[recent] != COUNT_FULL)
            readers[recent] = readers[recent] + COUNT_W'(1);
          res.slot_out = recent;
        end else begin
          res.status = ST_NOTHING;
        end
      end
      OP_RELEASE: begin
        if (int'(req.slot) >= usable) res.status = ST_INVALID;
        else if (readers[req.slot] == '0) res.status = ST_UNUSED;
        else readers[req.slot] = readers[req.slot] - COUNT_W'(1);
      end
      default: ;
    endcase
    return res;
  endfunction

  // sample both channels and the register port at every edge
  always @(posedge clk) begin
    cab_out_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) readers[i] = '0;
      have_recent = 1'b0;
      recent = '0;
      slot_limit = CFG_RESET;
      expected_results.delete();
      errors = 0;
      checked = 0;
      error_results = 0;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) slot_limit = cfg_wr_data;
      // compare a delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d slot_out %0d",
                 out_data.status, out_data.slot_out);
          errors++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.status != ST_OK) error_results++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, actual %0d", want.slot_out, out_data.slot_out);
            errors++;
          end
        end
      end
      // predict on request accept
      if (in_valid && !in_stall) expected_results.push_back(predict_result(in_data));
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== tb/tb_cyclic_async_buffer_slot_manager.sv =====
// testbench top: drives slot manager requests, register settings and receiver stalls
module tb_cyclic_async_buffer_slot_manager;
  timeunit 1ns;
  timeprecision 1ps;
  import cab_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_START = 3000;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE = 3 + NUM_SLOTS + 4;
  localparam int PHASES = 11;
  localparam int PHASE_REQS = 100;
  localparam int SAT_READS = 260;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  cab_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  cab_out_t         out_data;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  int errors;
  int outstanding;
  int checked;
  int error_results;
  int cycles = 0;
  int sent = 0;
  int settings = 0;
  int idle_rate = 0;
  int usable_now = NUM_SLOTS;
  bit calm = 1'b0;

  cyclic_async_buffer_slot_manager dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  cab_slot_checker slot_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .checked      (checked),
    .error_results(error_results)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cyclic_async_buffer_slot_manager: mismatch");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off to back the block up
  initial begin
    int span;
    int rate;
    int n;
    bit held;
    span = 0;
    rate = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && span >= HOLD_START) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        span += HOLD_LEN;
      end else if (!calm && rate != 0 && $urandom_range(0, 9) < rate) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        span += n;
      end
      @(posedge clk);
      span++;
      if ($urandom_range(0, 149) == 0) rate = $urandom_range(0, 4);
    end
  end

  // offer one request and hold it until accepted, then maybe idle
  task automatic send_req(input op_t op, input logic [SLOT_W-1:0] sl);
    cab_in_t req;
    req.op = op;
    req.slot = sl;
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!calm && idle_rate != 0 && $urandom_range(0, 9) < idle_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // change the slot count while the block is idle
  task automatic set_limit(input logic [CFG_W-1:0] value);
    drain();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings++;
    usable_now = (int'(value) > NUM_SLOTS) ? NUM_SLOTS : int'(value);
  endtask

  // one random request, releases aimed mostly at usable slots
  task automatic random_req(input int w_write, input int w_read);
    int                r;
    op_t               op;
    logic [SLOT_W-1:0] sl;
    r = $urandom_range(0, 99);
    sl = SLOT_W'($urandom_range(0, 7));
    if (r < w_write) begin
      op = OP_WRITE;
    end else if (r < w_write + w_read) begin
      op = OP_READ;
    end else if (r < 95) begin
      op = OP_RELEASE;
      if (usable_now != 0 && $urandom_range(0, 4) != 0)
        sl = SLOT_W'($urandom_range(0, usable_now - 1));
    end else begin
      op = OP_NONE;
    end
    send_req(op, sl);
  endtask

  // stimulus and verdict
  initial begin
    int pool [6];
    int ww;
    int wr;
    pool = '{1, 15, 0, 2, 9, 8};
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= CFG_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setting, nothing written, empty releases, claims and reads
    send_req(OP_READ, 3'd7);
    send_req(OP_RELEASE, 3'd0);
    send_req(OP_RELEASE, 3'd7);
    send_req(OP_NONE, 3'd7);
    send_req(OP_WRITE, 3'd7);
    send_req(OP_READ, 3'd0);
    send_req(OP_WRITE, 3'd0);
    send_req(OP_WRITE, 3'd5);
    send_req(OP_READ, 3'd2);
    send_req(OP_RELEASE, 3'd0);
    send_req(OP_RELEASE, 3'd0);
    send_req(OP_WRITE, 3'd0);
    // one slot: the newest is the only one, so no free slot
    set_limit(CFG_W'(1));
    send_req(OP_WRITE, 3'd0);
    send_req(OP_READ, 3'd0);
    send_req(OP_RELEASE, 3'd2);
    // zero slots: every op fails
    set_limit(CFG_W'(0));
    send_req(OP_WRITE, 3'd0);
    send_req(OP_READ, 3'd0);
    send_req(OP_RELEASE, 3'd0);
    // above the limit saturates; pin slots so the newest climbs
    set_limit(CFG_W'(15));
    repeat (4) begin
      send_req(OP_WRITE, 3'd0);
      send_req(OP_READ, 3'd0);
    end
    send_req(OP_RELEASE, 3'd7);
    // shrink so the newest may fall outside the range
    set_limit(CFG_W'(2));
    send_req(OP_READ, 3'd0);
    send_req(OP_WRITE, 3'd0);

    // random phases over several slot counts
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 6) set_limit(CFG_W'(pool[ph]));
      else set_limit(CFG_W'($urandom_range(0, 15)));
      idle_rate = $urandom_range(0, 4);
      ww = $urandom_range(15, 35);
      wr = $urandom_range(20, 45);
      repeat (PHASE_REQS) random_req(ww, wr);
    end

    // last part, no idling: drive one count to saturation, then release all slots
    calm = 1'b1;
    idle_rate = 0;
    set_limit(USABLE_MAX);
    send_req(OP_WRITE, 3'd0);
    repeat (SAT_READS) send_req(OP_READ, SLOT_W'($urandom_range(0, 7)));
    for (int s = 0; s < 8; s++) send_req(OP_RELEASE, SLOT_W'(s));
    send_req(OP_WRITE, 3'd0);
    send_req(OP_READ, 3'd0);
    drain();

    $display("ran %0d requests over %0d register writes, %0d results checked",
             sent, settings, checked);
    $display("%0d results carried an error status; one long receiver hold-off included",
             error_results);
    if (errors == 0) begin
      $display("cyclic_async_buffer_slot_manager: match");
    end else begin
      $display("cyclic_async_buffer_slot_manager: mismatch");
    end
    $finish;
  end

endmodule
